/* design/sgcw_pkg.sv */
// Shared constants and types of the segment grid cell walk.
`default_nettype none

package sgcw_pkg;

    // Default geometry
    localparam int CELL_SHIFT_DEF = 10;
    localparam int MAP_CELLS_DEF  = 32;

    // Field widths of the channels
    localparam int SEG_ID_W   = 15;
    localparam int COARSE_W   = 7;
    localparam int CELL_OUT_W = 5;

    // Coarse to world scaling and ladder side offset
    localparam int COARSE_SH = 8;
    localparam int LADDER_SH = 3;

    // World coordinates after the ladder offset, signed
    localparam int COORD_W = 18;
    // Magnitude of a delta
    localparam int MAG_W   = 16;

    // Shared multiplier operand width, and n/3 = (n * THIRD_K) >> THIRD_SH for n < 2^16
    localparam int                MUL_W    = 16;
    localparam logic [MUL_W-1:0]  THIRD_K  = 16'd43691;
    localparam int                THIRD_SH = 17;

    // Most cells given out for one segment
    localparam int MAX_OUT = 64;

    // Request from the walk sequencer to the output stage
    typedef struct packed {
        logic                  push;
        logic                  finish;
        logic [CELL_OUT_W-1:0] cx;
        logic [CELL_OUT_W-1:0] cz;
    } t_emit_req;

endpackage

`default_nettype wire

/* design/sgcw_ifs.sv */
// Valid/ready channel interfaces for segment items and cell items.
`default_nettype none

interface sgcw_seg_if;
    logic                          valid;
    logic                          ready;
    logic [sgcw_pkg::SEG_ID_W-1:0] segment_id;
    logic [sgcw_pkg::COARSE_W-1:0] start_x;
    logic [sgcw_pkg::COARSE_W-1:0] start_z;
    logic [sgcw_pkg::COARSE_W-1:0] end_x;
    logic [sgcw_pkg::COARSE_W-1:0] end_z;
    logic                          is_ladder;

    modport source (output valid, segment_id, start_x, start_z, end_x, end_z, is_ladder,
                    input ready);
    modport sink (input valid, segment_id, start_x, start_z, end_x, end_z, is_ladder,
                  output ready);
endinterface

interface sgcw_cell_if;
    logic                            valid;
    logic                            ready;
    logic [sgcw_pkg::CELL_OUT_W-1:0] cell_x;
    logic [sgcw_pkg::CELL_OUT_W-1:0] cell_z;
    logic [sgcw_pkg::SEG_ID_W-1:0]   segment_tag;
    logic                            last_cell;

    modport source (output valid, cell_x, cell_z, segment_tag, last_cell, input ready);
    modport sink (input valid, cell_x, cell_z, segment_tag, last_cell, output ready);
endinterface

`default_nettype wire

/* design/sgcw_div.sv */
// Restoring divider: quotient of (num << CELL_SHIFT) / den, one bit per cycle, num <= den.
`default_nettype none

module sgcw_div #(
    parameter int CELL_SHIFT = sgcw_pkg::CELL_SHIFT_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [sgcw_pkg::MAG_W-1:0]  i_num,
    input  logic [sgcw_pkg::MAG_W-1:0]  i_den,
    output logic                        o_done,
    output logic [CELL_SHIFT:0]         o_quot
);
    import sgcw_pkg::*;

    localparam int STEP_W = $clog2(CELL_SHIFT + 1);

    logic              r_busy;
    logic              r_done;
    logic [STEP_W-1:0] r_step;
    logic [MAG_W:0]    r_rem;
    logic [MAG_W-1:0]  r_den;
    logic [CELL_SHIFT:0] r_quot;

    logic           ge;
    logic [MAG_W:0] diff;

    // Trial subtract of the partial remainder
    always_comb begin
        ge   = r_rem >= {1'b0, r_den};
        diff = ge ? (r_rem - {1'b0, r_den}) : r_rem;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            // Done pulses for one cycle after the last quotient bit
            r_done <= r_busy && !i_start && (r_step == '0);
            if (i_start) begin
                r_busy <= 1'b1;
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_step <= STEP_W'(CELL_SHIFT);
                r_quot <= '0;
            end else if (r_busy) begin
                // diff < den, so doubling it still fits
                r_rem  <= {diff[MAG_W-1:0], 1'b0};
                r_quot <= {r_quot[CELL_SHIFT-1:0], ge};
                if (r_step == '0) begin
                    r_busy <= 1'b0;
                end else begin
                    r_step <= r_step - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;

endmodule

`default_nettype wire

/* design/sgcw_emit.sv */
// Output stage: one held cell so the final one can carry last_cell, then the output register.
`default_nettype none

module sgcw_emit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sgcw_pkg::t_emit_req            i_req,
    input  logic [sgcw_pkg::SEG_ID_W-1:0]  i_tag,
    output logic                           o_ok,
    sgcw_cell_if.source                    o_cell
);
    import sgcw_pkg::*;

    logic                  r_pend_valid;
    logic [CELL_OUT_W-1:0] r_pend_x;
    logic [CELL_OUT_W-1:0] r_pend_z;
    logic                  r_out_valid;
    logic [CELL_OUT_W-1:0] r_out_x;
    logic [CELL_OUT_W-1:0] r_out_z;
    logic [SEG_ID_W-1:0]   r_out_tag;
    logic                  r_out_last;

    logic out_free;
    logic load_out;

    // The held cell moves on when a newer cell arrives or the walk ends
    always_comb begin
        out_free = !r_out_valid || o_cell.ready;
        o_ok     = !r_pend_valid || out_free;
        load_out = (i_req.push || i_req.finish) && r_pend_valid && out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (load_out) begin
                r_out_valid <= 1'b1;
                r_out_x     <= r_pend_x;
                r_out_z     <= r_pend_z;
                r_out_tag   <= i_tag;
                r_out_last  <= i_req.finish;
            end else if (o_cell.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_req.push && o_ok) begin
                r_pend_valid <= 1'b1;
                r_pend_x     <= i_req.cx;
                r_pend_z     <= i_req.cz;
            end else if (i_req.finish && o_ok) begin
                r_pend_valid <= 1'b0;
            end
        end
    end

    assign o_cell.valid       = r_out_valid;
    assign o_cell.cell_x      = r_out_x;
    assign o_cell.cell_z      = r_out_z;
    assign o_cell.segment_tag = r_out_tag;
    assign o_cell.last_cell   = r_out_last;

endmodule

`default_nettype wire

/* design/segment_grid_cell_walk.sv */
// Segment grid cell walk: turns a wall segment into the map cells that it crosses.
//
// Channels: i_seg takes one segment item (id, two coarse endpoints, ladder flag);
// o_cell gives the cells it touches in walk order, each tagged with the segment id,
// the final one with last_cell set. Both are valid/ready, taken when both are high.
// i_seg.ready is high only while the block is idle; a zero-length segment is taken
// and gives no cells, and the block stays ready.
// Per segment: setup on the shared multiplier (two thirds of the deltas, ladder shift,
// axis choice), the divider for the minor step, the first minor position, then one
// walk step per major cell plus one per minor crossing, and a closing step; a new
// segment is taken only once the sequencer is back in idle.
// At most 64 cells are given out per segment.
// The last found cell is held back one place so it can be flagged; a stalled
// receiver pauses the walk once both that hold place and the output register are full.
// Reset (synchronous, active low) returns the sequencer to idle and empties the
// output; there is no stored table to clear.
`default_nettype none

module segment_grid_cell_walk #(
    parameter int CELL_SHIFT = sgcw_pkg::CELL_SHIFT_DEF,
    parameter int MAP_CELLS  = sgcw_pkg::MAP_CELLS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sgcw_seg_if.sink    i_seg,
    sgcw_cell_if.source o_cell
);
    import sgcw_pkg::*;

    localparam int IDX_W = COORD_W - CELL_SHIFT + 1;
    localparam int CNT_W = $clog2(MAX_OUT + 1);
    localparam int CELL  = 1 << CELL_SHIFT;

    typedef enum logic [3:0] {
        S_IDLE, S_THX, S_THZ, S_ADJ, S_AXIS, S_DIV, S_MUL, S_BINIT, S_WALK, S_EXTRA, S_FIN
    } t_state;

    t_state r_state;

    logic [SEG_ID_W-1:0]       r_tag;
    logic                      r_ladder;
    logic signed [COORD_W-1:0] r_x1, r_z1, r_x2, r_z2;
    logic signed [COORD_W-1:0] r_dx, r_dz, r_tdx;
    logic [MUL_W-1:0]          r_mul_a, r_mul_b;
    logic [2*MUL_W-1:0]        r_prod;
    logic                      r_major_x, r_da_neg, r_frac_neg;
    logic signed [COORD_W-1:0] r_b1, r_frac, r_b;
    logic [CELL_SHIFT-1:0]     r_afrac;
    logic signed [IDX_W-1:0]   r_ma, r_mb, r_end_ma, r_end_mb;
    logic [CNT_W-1:0]          r_cnt;

    function automatic logic [MAG_W-1:0] mag_of(input logic signed [COORD_W-1:0] v);
        mag_of = v[COORD_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    function automatic logic in_map(input logic signed [IDX_W-1:0] c);
        in_map = !c[IDX_W-1] && (32'(c[IDX_W-2:0]) < 32'(MAP_CELLS));
    endfunction

    // Input endpoints in world units
    logic signed [COORD_W-1:0] in_x1, in_z1, in_x2, in_z2, in_dx, in_dz;
    logic                      in_take, in_zero;

    always_comb begin
        in_x1   = COORD_W'({i_seg.start_x, COARSE_SH'(0)});
        in_z1   = COORD_W'({i_seg.start_z, COARSE_SH'(0)});
        in_x2   = COORD_W'({i_seg.end_x, COARSE_SH'(0)});
        in_z2   = COORD_W'({i_seg.end_z, COARSE_SH'(0)});
        in_dx   = in_x2 - in_x1;
        in_dz   = in_z2 - in_z1;
        in_take = i_seg.valid && (r_state == S_IDLE);
        in_zero = (in_dx == '0) && (in_dz == '0);
    end

    // Third of a delta, truncated toward zero, from the shared product
    logic signed [COORD_W-1:0] third_mag, third_val, sx, sz;
    logic                      third_neg;

    always_comb begin
        third_mag = COORD_W'(r_prod >> THIRD_SH);
        third_neg = (r_state == S_THZ) ? r_dx[COORD_W-1] : r_dz[COORD_W-1];
        third_val = third_neg ? -third_mag : third_mag;
        sx        = r_dz >>> LADDER_SH;
        sz        = r_dx >>> LADDER_SH;
    end

    // Major axis choice and walk start
    logic signed [COORD_W-1:0] adj_dx, adj_dz, a1, b1, a2, b2, da, db;
    logic                      major_x, div_start;

    always_comb begin
        adj_dx    = r_x2 - r_x1;
        adj_dz    = r_z2 - r_z1;
        major_x   = mag_of(adj_dx) > mag_of(adj_dz);
        a1        = major_x ? r_x1 : r_z1;
        b1        = major_x ? r_z1 : r_x1;
        a2        = major_x ? r_x2 : r_z2;
        b2        = major_x ? r_z2 : r_x2;
        da        = a2 - a1;
        db        = b2 - b1;
        div_start = (r_state == S_AXIS) && (da != '0);
    end

    // Minor step from the divider
    logic                      div_done;
    logic [CELL_SHIFT:0]       div_quot;
    logic signed [COORD_W-1:0] quot_ext, n_frac;

    sgcw_div #(
        .CELL_SHIFT(CELL_SHIFT)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (mag_of(db)),
        .i_den   (mag_of(da)),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    always_comb begin
        quot_ext = COORD_W'(div_quot);
        n_frac   = r_frac_neg ? -quot_ext : quot_ext;
    end

    // First minor position: b1 corrected by frac times the major offset into the cell
    logic signed [2*MUL_W:0]   prod_s;
    logic signed [COORD_W-1:0] pterm;

    always_comb begin
        prod_s = r_frac_neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        pterm  = COORD_W'(prod_s >>> CELL_SHIFT);
    end

    // Walk step
    logic signed [COORD_W-1:0] n_b;
    logic signed [IDX_W-1:0]   n_mb, n_ma, cand_x, cand_z;
    logic                      cand_in, at_end, cap_hit, emit_ok, go;
    t_emit_req                 emit_req;

    always_comb begin
        n_b     = r_da_neg ? (r_b - r_frac) : (r_b + r_frac);
        n_mb    = IDX_W'(n_b >>> CELL_SHIFT);
        n_ma    = r_da_neg ? (r_ma - 1'b1) : (r_ma + 1'b1);
        cand_x  = r_major_x ? r_ma : r_mb;
        cand_z  = r_major_x ? r_mb : r_ma;
        cand_in = in_map(cand_x) && in_map(cand_z);
        at_end  = (r_ma == r_end_ma);

        emit_req.push   = ((r_state == S_WALK) || (r_state == S_EXTRA)) && cand_in;
        emit_req.finish = (r_state == S_FIN);
        emit_req.cx     = cand_x[CELL_OUT_W-1:0];
        emit_req.cz     = cand_z[CELL_OUT_W-1:0];

        go      = !emit_req.push || emit_ok;
        cap_hit = emit_req.push && (r_cnt == CNT_W'(MAX_OUT - 1));
    end

    sgcw_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (emit_req),
        .i_tag   (r_tag),
        .o_ok    (emit_ok),
        .o_cell  (o_cell)
    );

    assign i_seg.ready = (r_state == S_IDLE);

    // Shared multiplier, registered
    always_ff @(posedge i_clk) begin
        r_prod <= r_mul_a * r_mul_b;
    end

    // Sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_take && !in_zero) begin
                        r_tag    <= i_seg.segment_id;
                        r_ladder <= i_seg.is_ladder;
                        r_x1     <= in_x1;
                        r_z1     <= in_z1;
                        r_x2     <= in_x2;
                        r_z2     <= in_z2;
                        r_dx     <= in_dx;
                        r_dz     <= in_dz;
                        r_mul_a  <= mag_of(in_dx);
                        r_mul_b  <= THIRD_K;
                        r_state  <= S_THX;
                    end
                end
                S_THX: begin
                    r_mul_a <= mag_of(r_dz);
                    r_state <= S_THZ;
                end
                S_THZ: begin
                    r_tdx   <= third_val;
                    r_state <= S_ADJ;
                end
                S_ADJ: begin
                    // Ladder: pull both ends in by a third, shift sideways
                    if (r_ladder) begin
                        r_x1 <= r_x1 + r_tdx + sx;
                        r_x2 <= r_x2 - r_tdx + sx;
                        r_z1 <= r_z1 + third_val - sz;
                        r_z2 <= r_z2 - third_val - sz;
                    end
                    r_state <= S_AXIS;
                end
                S_AXIS: begin
                    r_major_x  <= major_x;
                    r_da_neg   <= da[COORD_W-1];
                    r_frac_neg <= da[COORD_W-1] ^ db[COORD_W-1];
                    r_b1       <= b1;
                    r_afrac    <= a1[CELL_SHIFT-1:0];
                    r_ma       <= IDX_W'(a1 >>> CELL_SHIFT);
                    r_mb       <= IDX_W'(b1 >>> CELL_SHIFT);
                    r_end_ma   <= IDX_W'(a2 >>> CELL_SHIFT);
                    r_end_mb   <= IDX_W'(b2 >>> CELL_SHIFT);
                    r_state    <= (da == '0) ? S_FIN : S_DIV;
                end
                S_DIV: begin
                    if (div_done) begin
                        r_frac  <= n_frac;
                        r_mul_a <= MUL_W'(div_quot);
                        r_mul_b <= r_da_neg ? (MUL_W'(CELL) - MUL_W'(r_afrac))
                                            : MUL_W'(r_afrac);
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_BINIT;
                end
                S_BINIT: begin
                    r_b     <= r_da_neg ? (r_b1 + pterm) : (r_b1 - pterm);
                    r_cnt   <= '0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    if (go) begin
                        if (emit_req.push) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (cap_hit || (at_end && (r_mb == r_end_mb))) begin
                            r_state <= S_FIN;
                        end else begin
                            r_b <= n_b;
                            if (n_mb != r_mb) begin
                                // Minor coordinate entered a new cell
                                r_mb    <= n_mb;
                                r_state <= S_EXTRA;
                            end else if (at_end) begin
                                r_state <= S_FIN;
                            end else begin
                                r_ma <= n_ma;
                            end
                        end
                    end
                end
                S_EXTRA: begin
                    if (go) begin
                        if (emit_req.push) begin
                            r_cnt <= r_cnt + 1'b1;
                        end
                        if (cap_hit || at_end) begin
                            r_state <= S_FIN;
                        end else begin
                            r_ma    <= n_ma;
                            r_state <= S_WALK;
                        end
                    end
                end
                S_FIN: begin
                    if (emit_ok) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

/* design/sgcw_chk.sv */
// Port-level checks of the segment grid cell walk, bound to the top level.
`default_nettype none

module sgcw_chk #(
    parameter int MAP_CELLS = sgcw_pkg::MAP_CELLS_DEF
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_in_valid,
    input logic                              i_in_ready,
    input logic [sgcw_pkg::COARSE_W-1:0]     i_start_x,
    input logic [sgcw_pkg::COARSE_W-1:0]     i_start_z,
    input logic [sgcw_pkg::COARSE_W-1:0]     i_end_x,
    input logic [sgcw_pkg::COARSE_W-1:0]     i_end_z,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic [sgcw_pkg::CELL_OUT_W-1:0]   i_cell_x,
    input logic [sgcw_pkg::CELL_OUT_W-1:0]   i_cell_z
);

    // Reset leaves the output empty and the block ready for a segment
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_out_valid && i_in_ready))
        else $error("block not idle after reset");

    // A cell that waits is not withdrawn
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid)
        else $error("output cell dropped while stalled");

    // A segment of nonzero length keeps the block busy
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && ((i_start_x != i_end_x) || (i_start_z != i_end_z)))
        |=> !i_in_ready)
        else $error("ready right after a nonzero segment");

    // Cells lie inside the map
    a_in_map: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((MAP_CELLS >= 32) ||
                         ((i_cell_x < MAP_CELLS) && (i_cell_z < MAP_CELLS))))
        else $error("cell outside the map");

endmodule

bind segment_grid_cell_walk sgcw_chk #(
    .MAP_CELLS(MAP_CELLS)
) u_sgcw_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_seg.valid),
    .i_in_ready  (i_seg.ready),
    .i_start_x   (i_seg.start_x),
    .i_start_z   (i_seg.start_z),
    .i_end_x     (i_seg.end_x),
    .i_end_z     (i_seg.end_z),
    .i_out_valid (o_cell.valid),
    .i_out_ready (o_cell.ready),
    .i_cell_x    (o_cell.cell_x),
    .i_cell_z    (o_cell.cell_z)
);

`default_nettype wire
